[hw/rtl/mprb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprb_pkg
// Shared types and constants of the MMU page-table register block.
// ----------------------------------------------------------------------------
package mprb_pkg;

    // Register offsets within the block
    localparam logic [11:0] OFS_CACHE_CTRL = 12'h03C;
    localparam logic [11:0] OFS_CALI       = 12'h170;
    localparam logic [11:0] OFS_FIFO       = 12'h178;
    localparam logic [11:0] OFS_CONTENT    = 12'h37C;
    localparam logic [11:0] OFS_INDEX      = 12'h380;
    localparam logic [11:0] OFS_POWER      = 12'h384;

    // Fixed status words and reset values
    localparam logic [31:0] CALI_DONE_WORD  = 32'h8000_0000;
    localparam logic [31:0] FIFO_EMPTY_WORD = 32'hFC00_0000;
    localparam logic [31:0] POWER_RESET     = 32'h0000_0004;
    localparam logic [26:0] WINDOW_RESET    = 27'd33554432;

    // Page size: 64 KB shifted down by the power-control select field
    localparam logic [4:0]  PAGE_SHIFT_MAX  = 5'd16;

    // Configuration register indexes
    localparam logic [1:0]  CFG_LOAD_ENABLE = 2'd0;
    localparam logic [1:0]  CFG_WINDOW      = 2'd1;

    // Access actions
    localparam logic        ACT_READ        = 1'b0;
    localparam logic        ACT_WRITE       = 1'b1;

    typedef struct packed {
        logic        action;
        logic [11:0] reg_addr;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        load_issue;
        logic        load_fill;
        logic [31:0] flash_offset;
        logic [31:0] cache_offset;
        logic [16:0] page_bytes;
    } t_out_item;

endpackage : mprb_pkg
`default_nettype wire

[hw/rtl/mprb_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprb_table
// MMU entry memory: one write port, one registered read port with
// same-cycle write forwarding, and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module mprb_table
    import mprb_pkg::*;
#(
    parameter int ENTRY_COUNT = 256,
    parameter int IDXW        = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [IDXW-1:0] i_rd_addr,
    input  wire logic            i_wr_en,
    input  wire logic [IDXW-1:0] i_wr_addr,
    input  wire logic [31:0]     i_wr_data,
    output logic      [31:0]     o_rd_data,
    output logic                 o_clearing
);

    localparam logic [IDXW-1:0] LAST_ENTRY = IDXW'(ENTRY_COUNT - 1);

    logic [31:0]     r_mem [ENTRY_COUNT];
    logic [31:0]     r_rd;
    logic            r_clr;
    logic [IDXW-1:0] r_clr_cnt;

    logic            mem_we;
    logic [IDXW-1:0] mem_addr;
    logic [31:0]     mem_data;

    // Sweep has the port while clearing
    always_comb begin
        mem_we   = r_clr | i_wr_en;
        mem_addr = r_clr ? r_clr_cnt : i_wr_addr;
        mem_data = r_clr ? 32'd0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_data;
        end
    end

    // Forward a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_clr) begin
            if (r_clr_cnt == LAST_ENTRY) begin
                r_clr <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + IDXW'(1);
            end
        end
    end

    assign o_rd_data  = r_rd;
    assign o_clearing = r_clr;

endmodule : mprb_table
`default_nettype wire

[hw/rtl/mprb_exec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprb_exec
// Register file and access decode: reads, register updates, entry writes
// and page-load command generation.
// ----------------------------------------------------------------------------
module mprb_exec
    import mprb_pkg::*;
#(
    parameter int ENTRY_COUNT   = 256,
    parameter int PAGE_NUM_BITS = 9,
    parameter int VALID_BIT_POS = 9,
    parameter int IDXW          = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_commit,
    input  wire t_in_item        i_item,
    input  wire logic [31:0]     i_entry,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    output t_out_item            o_result,
    output logic                 o_wr_en,
    output logic      [IDXW-1:0] o_wr_addr,
    output logic      [31:0]     o_wr_data,
    output logic      [IDXW-1:0] o_rd_addr
);

    logic [31:0] r_cache_ctrl;
    logic [31:0] r_index;
    logic [31:0] r_power;
    logic        r_load_en;
    logic [26:0] r_window;

    logic        is_write;
    logic        in_range;
    logic [4:0]  shamt;
    logic [16:0] psz;
    logic [31:0] voff;
    logic [32:0] vend;
    logic        fits;
    logic        issue;
    logic        entry_valid;
    logic [31:0] pnum;
    logic [31:0] next_index;

    always_comb begin
        is_write    = (i_item.action == ACT_WRITE);
        in_range    = (r_index < 32'(ENTRY_COUNT));
        shamt       = PAGE_SHIFT_MAX - {3'b000, r_power[4:3]};
        psz         = 17'd1 << shamt;
        voff        = r_index << shamt;
        vend        = {1'b0, voff} + 33'(psz);
        fits        = (vend <= 33'(r_window));
        issue       = is_write && (i_item.reg_addr == OFS_CONTENT) && in_range
                      && r_load_en && fits;
        entry_valid = i_item.write_data[VALID_BIT_POS];
        pnum        = 32'(i_item.write_data[PAGE_NUM_BITS-1:0]);

        o_result = '0;
        if (!is_write) begin
            case (i_item.reg_addr)
                OFS_CACHE_CTRL: o_result.read_data = r_cache_ctrl;
                OFS_CALI:       o_result.read_data = CALI_DONE_WORD;
                OFS_FIFO:       o_result.read_data = FIFO_EMPTY_WORD;
                OFS_CONTENT:    o_result.read_data = in_range ? i_entry : 32'd0;
                OFS_INDEX:      o_result.read_data = r_index;
                OFS_POWER:      o_result.read_data = r_power;
                default:        o_result.read_data = 32'd0;
            endcase
        end
        if (issue) begin
            o_result.load_issue   = 1'b1;
            o_result.load_fill    = !entry_valid;
            o_result.flash_offset = entry_valid ? (pnum << shamt) : 32'd0;
            o_result.cache_offset = voff;
            o_result.page_bytes   = psz;
        end

        o_wr_en   = i_commit && is_write && (i_item.reg_addr == OFS_CONTENT) && in_range;
        o_wr_addr = r_index[IDXW-1:0];
        o_wr_data = i_item.write_data;

        // Read the entry that the next access will see
        next_index = (i_commit && is_write && (i_item.reg_addr == OFS_INDEX))
                     ? i_item.write_data : r_index;
        o_rd_addr  = next_index[IDXW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_ctrl <= '0;
            r_index      <= '0;
            r_power      <= POWER_RESET;
            r_load_en    <= 1'b1;
            r_window     <= WINDOW_RESET;
        end else begin
            if (i_commit && is_write) begin
                case (i_item.reg_addr)
                    OFS_CACHE_CTRL: r_cache_ctrl <= i_item.write_data;
                    OFS_INDEX:      r_index      <= i_item.write_data;
                    OFS_POWER:      r_power      <= i_item.write_data;
                    default:        ;
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOAD_ENABLE: r_load_en <= i_cfg_data[0];
                    CFG_WINDOW:      r_window  <= i_cfg_data[26:0];
                    default:         ;
                endcase
            end
        end
    end

endmodule : mprb_exec
`default_nettype wire

[hw/rtl/mmu_page_table_register_block_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// An input beat passes the input register, then the result register, to become a result beat.
// Throughput: one access per cycle unless the result channel stalls or the table is zeroed;
// the entry memory read is registered with the input and the decode fits in the single stage.
// Reset: synchronous, active low. After reset the block zeroes all ENTRY_COUNT MMU table
// entries, one entry per cycle, and stalls input until done;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// mmu_page_table_register_block_core
// Bus-register model of a flash cache MMU with page-load command output.
// ----------------------------------------------------------------------------
module mmu_page_table_register_block_core
    import mprb_pkg::*;
#(
    parameter int ENTRY_COUNT   = 256,
    parameter int PAGE_NUM_BITS = 9,
    parameter int VALID_BIT_POS = 9
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // access channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IDXW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    // Stage 1: accepted access beat
    logic      r_s1_vld;
    t_in_item  r_s1;
    // Stage 2: result beat waiting for the consumer
    logic      r_out_vld;
    t_out_item r_out;

    logic            adv;
    logic            commit;
    logic            clearing;
    logic [31:0]     entry;
    t_out_item       result;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    logic [31:0]     wr_data;
    logic [IDXW-1:0] rd_addr;

    // Advance the whole pipe whenever the result register is free or drains
    assign adv    = !r_out_vld || !i_out_stall;
    assign commit = r_s1_vld && adv;

    // Hold off access beats while the pipe is blocked or the table is being zeroed
    assign o_in_stall  = !adv || clearing;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s1_vld;
            r_s1_vld  <= i_in_valid && !clearing;
        end
    end

    // Payload registers: advance with the pipe, no reset
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
            r_s1  <= i_in_data;
        end
    end

    // Decode, register state and command generation for the beat in stage 1
    mprb_exec #(
        .ENTRY_COUNT   (ENTRY_COUNT),
        .PAGE_NUM_BITS (PAGE_NUM_BITS),
        .VALID_BIT_POS (VALID_BIT_POS),
        .IDXW          (IDXW)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (commit),
        .i_item      (r_s1),
        .i_entry     (entry),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr)
    );

    // Entry memory: read the entry at the index the next beat will use, on
    // the same edge that moves that beat into stage 1
    mprb_table #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDXW        (IDXW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (adv),
        .i_rd_addr  (rd_addr),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .o_rd_data  (entry),
        .o_clearing (clearing)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule : mmu_page_table_register_block_core
`default_nettype wire
